// File: hdl/wsa_pkg.sv
// Shared types and constants for the weighted scatter average block.
`timescale 1ns / 1ps
package wsa_pkg;
	localparam int PARTICLE_COUNT_DEF = 1024;
	localparam int IDX_W = 10;
	localparam int AXES = 3;
	localparam int SUM_W = 64;
	localparam int WS_W = 32;
	localparam int DIV_STEPS = 64;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_ACC, ST_WR, ST_DIV_START, ST_DIV_WAIT, ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_wr;
		logic load_in;
		logic acc_wr;
		logic rd_clear;
		logic div_start;
		logic out_load;
		logic oor_out;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic div_last;
		logic ws_zero;
	} stat_t;
endpackage

// File: hdl/wsa_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module wsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/wsa_datapath.sv
// Datapath: sum memories, multiply-accumulate, shared restoring divider.
`timescale 1ns / 1ps
module wsa_datapath import wsa_pkg::*; #(
	parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [IDX_W-1:0]  particle_index,
	input  logic [15:0]       weight,
	input  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
	output logic [IDX_W-1:0]  out_index,
	output logic              no_update,
	output logic              saturated,
	output logic signed [31:0] avg_pos_x, avg_pos_y, avg_pos_z,
	output logic signed [31:0] avg_vel_x, avg_vel_y, avg_vel_z
);
	localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
	localparam int NV = 2 * AXES;

	logic [AW-1:0]       clr_addr_q;
	logic [IDX_W-1:0]    idx_q;
	logic [15:0]         w_q;
	logic signed [31:0]  vec_q [NV];
	logic [AW-1:0]       addr;
	logic                we;
	logic [SUM_W-1:0]    wdat [NV];
	logic [SUM_W-1:0]    rdat [NV];
	logic [WS_W-1:0]     ws_wdat, ws_rdat;
	logic signed [47:0]  prod_s1 [NV];
	logic [2:0]          div_sel_q;
	logic [SUM_W-1:0]    rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [6:0]          bit_cnt_q;
	logic                div_busy_q;
	logic                neg_q;
	logic signed [31:0]  res_q [NV];
	logic                sat_q;
	logic [SUM_W-1:0]    num_mag;
	logic [SUM_W:0]      trial;

	assign addr = cmd.clr_wr ? clr_addr_q : idx_q[AW-1:0];
	assign we = cmd.clr_wr | cmd.acc_wr | cmd.rd_clear;

	// Sweep clear address after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end
	assign stat.clr_done = (32'(clr_addr_q) == PARTICLE_COUNT - 1);

	// Capture transaction payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			idx_q <= particle_index;
			w_q <= weight;
			vec_q[0] <= pos_x; vec_q[1] <= pos_y; vec_q[2] <= pos_z;
			vec_q[3] <= vel_x; vec_q[4] <= vel_y; vec_q[5] <= vel_z;
		end
	end

	// Products registered while the sums are read
	always_ff @(posedge clk) begin
		for (int i = 0; i < NV; i++) begin
			prod_s1[i] <= vec_q[i] * $signed({1'b0, w_q});
		end
	end

	// Saturating sums for the write port
	always_comb begin
		logic signed [SUM_W:0] s;
		logic [WS_W:0] ws;
		for (int i = 0; i < NV; i++) begin
			s = $signed({rdat[i][SUM_W-1], rdat[i]}) + (SUM_W+1)'(prod_s1[i]);
			if (!cmd.acc_wr) wdat[i] = '0;
			else if (s[SUM_W] != s[SUM_W-1])
				wdat[i] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
			else wdat[i] = s[SUM_W-1:0];
		end
		ws = {1'b0, ws_rdat} + (WS_W+1)'(w_q);
		if (!cmd.acc_wr) ws_wdat = '0;
		else ws_wdat = ws[WS_W] ? '1 : ws[WS_W-1:0];
	end

	for (genvar g = 0; g < NV; g++) begin : g_sum
		wsa_ram #(.WIDTH(SUM_W), .DEPTH(PARTICLE_COUNT)) u_ram (
			.clk(clk), .we(we), .waddr(addr), .wdata(wdat[g]),
			.raddr(addr), .rdata(rdat[g])
		);
	end
	wsa_ram #(.WIDTH(WS_W), .DEPTH(PARTICLE_COUNT)) u_ws (
		.clk(clk), .we(we), .waddr(addr), .wdata(ws_wdat),
		.raddr(addr), .rdata(ws_rdat)
	);

	assign stat.ws_zero = (ws_rdat == '0);
	assign num_mag = rdat[div_sel_q][SUM_W-1] ? -rdat[div_sel_q] : rdat[div_sel_q];
	assign trial = {rem_q, quo_q[SUM_W-1]} - {{(SUM_W-WS_W+1){1'b0}}, ws_rdat};
	assign stat.div_done = div_busy_q && bit_cnt_q == 7'(DIV_STEPS);
	assign stat.div_last = (div_sel_q == 3'(NV - 1));

	// Shared restoring divider, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_sel_q <= '0;
			bit_cnt_q <= '0;
			sat_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				div_sel_q <= '0;
				sat_q <= 1'b0;
			end
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				bit_cnt_q <= '0;
				rem_q <= '0;
				quo_q <= num_mag;
				neg_q <= rdat[div_sel_q][SUM_W-1];
			end else if (div_busy_q && !stat.div_done) begin
				bit_cnt_q <= bit_cnt_q + 7'd1;
				if (!trial[SUM_W]) begin
					rem_q <= trial[SUM_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[SUM_W-2:0], quo_q[SUM_W-1]};
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
			end else if (stat.div_done) begin
				div_busy_q <= 1'b0;
				div_sel_q <= div_sel_q + 3'd1;
				if (neg_q) begin
					if (quo_q > 64'h8000_0000) begin
						sat_q <= 1'b1; res_q[div_sel_q] <= 32'sh8000_0000;
					end else res_q[div_sel_q] <= -quo_q[31:0];
				end else begin
					if (quo_q > 64'h7FFF_FFFF) begin
						sat_q <= 1'b1; res_q[div_sel_q] <= 32'sh7FFF_FFFF;
					end else res_q[div_sel_q] <= quo_q[31:0];
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_index <= idx_q;
			if (cmd.oor_out) begin
				no_update <= 1'b1; saturated <= 1'b0;
				avg_pos_x <= '0; avg_pos_y <= '0; avg_pos_z <= '0;
				avg_vel_x <= '0; avg_vel_y <= '0; avg_vel_z <= '0;
			end else begin
				no_update <= 1'b0; saturated <= sat_q;
				avg_pos_x <= res_q[0]; avg_pos_y <= res_q[1]; avg_pos_z <= res_q[2];
				avg_vel_x <= res_q[3]; avg_vel_y <= res_q[4]; avg_vel_z <= res_q[5];
			end
		end
	end
endmodule

// File: hdl/wsa_ctrl.sv
// Controller state machine sequencing clear, accumulate and read.
`timescale 1ns / 1ps
module wsa_ctrl import wsa_pkg::*; #(
	parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	input  logic [IDX_W-1:0] particle_index,
	input  logic             cluster_selected,
	input  logic             slot_unused,
	output logic             out_valid,
	input  logic             out_ready,
	output cmd_t             cmd,
	input  stat_t            stat
);
	state_t state_q, state_d;
	logic   op_q, ov_q, ov_d, oor_q;
	logic   take;

	assign out_valid = ov_q;
	assign take = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ov_q <= 1'b0;
			op_q <= 1'b0;
			oor_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			if (take) begin
				op_q <= op;
				oor_q <= 32'(particle_index) >= PARTICLE_COUNT;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		ov_d = ov_q && !out_ready;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (op) state_d = ST_RD;
					else if (cluster_selected && !slot_unused
						&& 32'(particle_index) < PARTICLE_COUNT) state_d = ST_RD;
				end
			end
			ST_RD: begin
				if (op_q) begin
					if (oor_q) state_d = ST_OUT;
					else state_d = ST_DIV_START;
				end else state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIV_START: begin
				// Skip division altogether on an empty weight sum
				if (stat.ws_zero) begin
					state_d = ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) state_d = stat.div_last ? ST_OUT : ST_DIV_START;
			end
			ST_OUT: begin
				if (!ov_d) begin
					cmd.out_load = 1'b1;
					cmd.oor_out = oor_q || stat.ws_zero;
					cmd.rd_clear = !oor_q;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: hdl/weighted_scatter_average_top.sv
// Top level of the weighted scatter average block.
// An accumulate transaction runs through accept, read with multiply and
// write back; an ignored contribution is done once it is accepted.
// A read transaction runs a shared 64-step restoring divider six times; a
// zero weight sum or out-of-range index skips division. After reset a
// clearing pass over all PARTICLE_COUNT entries zeroes the sums before the
// first transaction is accepted. Results wait in an output register.
`timescale 1ns / 1ps
module weighted_scatter_average_top import wsa_pkg::*; #(
	parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [IDX_W-1:0]   particle_index,
	input  logic               cluster_selected,
	input  logic               slot_unused,
	input  logic [15:0]        weight,
	input  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   out_index,
	output logic               no_update,
	output logic               saturated,
	output logic signed [31:0] avg_pos_x, avg_pos_y, avg_pos_z,
	output logic signed [31:0] avg_vel_x, avg_vel_y, avg_vel_z
);
	cmd_t  cmd;
	stat_t stat;

	wsa_ctrl #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .op, .particle_index,
		.cluster_selected, .slot_unused, .out_valid, .out_ready, .cmd, .stat
	);

	wsa_datapath #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .stat, .particle_index, .weight,
		.pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z,
		.out_index, .no_update, .saturated,
		.avg_pos_x, .avg_pos_y, .avg_pos_z, .avg_vel_x, .avg_vel_y, .avg_vel_z
	);
endmodule
